// ----- design/sconv_pkg.sv -----
// Package for the separable convolution block: constants, beat types and helpers.
package sconv_pkg;

   // Frame store geometry
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int COL_BITS   = 8;
   localparam int ROW_BITS   = 8;
   localparam int ADDR_BITS  = COL_BITS + ROW_BITS;
   localparam int MEM_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int PIXEL_BITS = 8;

   // Kernel
   localparam int MAX_TAPS     = 5;
   localparam int MAX_HALF     = (MAX_TAPS - 1) / 2;
   localparam int COEFF_BITS   = 12;
   localparam int KERNEL_BITS  = 60;
   localparam int TAP_BITS     = 3;
   localparam int HALF_BITS    = 2;
   localparam int DIM_BITS     = 9;
   localparam int PROD_BITS    = COEFF_BITS + PIXEL_BITS + 1;
   localparam int ACC_BITS     = 32;

   // Border handling: clamp to edge
   localparam int CLAMP = 1;

   // Configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = KERNEL_BITS;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH   = 3'd0,
      CSR_IMAGE_HEIGHT  = 3'd1,
      CSR_HALF_TAPS     = 3'd2,
      CSR_KERNEL_X_TAPS = 3'd3,
      CSR_KERNEL_Y_TAPS = 3'd4
   } csr_index_type;

   // Reset values of the configuration registers
   localparam logic [DIM_BITS-1:0]    WIDTH_RESET  = DIM_BITS'(256);
   localparam logic [DIM_BITS-1:0]    HEIGHT_RESET = DIM_BITS'(256);
   localparam logic [HALF_BITS-1:0]   HALF_RESET   = HALF_BITS'(1);
   localparam logic [KERNEL_BITS-1:0] KERNEL_RESET = KERNEL_BITS'(4096);

   // Operation codes
   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_READ  = 1'b1
   } op_type;

   // Request beat
   typedef struct packed {
      logic                  op;
      logic [COL_BITS-1:0]   column;
      logic [ROW_BITS-1:0]   row;
      logic [PIXEL_BITS-1:0] pixel_in;
   } req_type;

   // Response beat
   typedef struct packed {
      logic signed [ACC_BITS-1:0] filtered;
      logic                       is_read;
   } rsp_type;

   // Tag that travels with each pixel fetch down the pipeline
   typedef struct packed {
      logic                row_first;
      logic                row_last;
      logic                frame_last;
      logic [TAP_BITS-1:0] tap_x;
      logic [TAP_BITS-1:0] tap_y;
   } tap_tag_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_ISSUE  = 2'd1,
      ST_DRAIN  = 2'd2,
      ST_FINISH = 2'd3
   } state_type;

   // Signed coefficient of one tap; taps beyond the kernel read as zero
   function automatic logic signed [COEFF_BITS-1:0] tap_coeff(
      input logic [KERNEL_BITS-1:0] taps,
      input logic [TAP_BITS-1:0]    idx
   );
      logic signed [COEFF_BITS-1:0] coeff;
      coeff = '0;
      if (int'(idx) < MAX_TAPS) begin
         coeff = taps[int'(idx)*COEFF_BITS +: COEFF_BITS];
      end
      return coeff;
   endfunction

endpackage

// ----- design/separable_convolution_clamp_top.sv -----
// Separable 2D convolution over a stored frame with clamp-to-edge borders.
// Write beat: pixel stored, zero response in the register next cycle.
// Read beat: (2*half_taps+1)^2 pixel fetches through the single frame store read port,
//   one per cycle, then the pipeline drains and the finish state loads the response register.
// One item is in work at a time; the next is taken once the response register frees.
// Synchronous reset restores configuration defaults and control state; frame store not cleared.
module separable_convolution_clamp_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  sconv_pkg::req_type                   req_data,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output sconv_pkg::rsp_type                   rsp_data,
   // configuration writes
   input  logic                                 csr_we,
   input  logic [sconv_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sconv_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   // Configuration registers
   logic [sconv_pkg::DIM_BITS-1:0]    width_ff;
   logic [sconv_pkg::DIM_BITS-1:0]    height_ff;
   logic [sconv_pkg::HALF_BITS-1:0]   half_ff;
   logic [sconv_pkg::KERNEL_BITS-1:0] kx_ff;
   logic [sconv_pkg::KERNEL_BITS-1:0] ky_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sconv_pkg::WIDTH_RESET;
         height_ff <= sconv_pkg::HEIGHT_RESET;
         half_ff   <= sconv_pkg::HALF_RESET;
         kx_ff     <= sconv_pkg::KERNEL_RESET;
         ky_ff     <= sconv_pkg::KERNEL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            sconv_pkg::CSR_IMAGE_WIDTH:   width_ff  <= csr_wdata[sconv_pkg::DIM_BITS-1:0];
            sconv_pkg::CSR_IMAGE_HEIGHT:  height_ff <= csr_wdata[sconv_pkg::DIM_BITS-1:0];
            sconv_pkg::CSR_HALF_TAPS:     half_ff   <= csr_wdata[sconv_pkg::HALF_BITS-1:0];
            sconv_pkg::CSR_KERNEL_X_TAPS: kx_ff     <= csr_wdata[sconv_pkg::KERNEL_BITS-1:0];
            sconv_pkg::CSR_KERNEL_Y_TAPS: ky_ff     <= csr_wdata[sconv_pkg::KERNEL_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Effective geometry: last valid column/row and saturated half size
   logic [sconv_pkg::COL_BITS-1:0]  col_last;
   logic [sconv_pkg::ROW_BITS-1:0]  row_last;
   logic [sconv_pkg::HALF_BITS-1:0] half_eff;
   logic [sconv_pkg::TAP_BITS-1:0]  tap_last;

   always_comb begin
      if (width_ff == '0) begin
         col_last = '0;
      end else if (int'(width_ff) > sconv_pkg::MAX_WIDTH) begin
         col_last = sconv_pkg::COL_BITS'(sconv_pkg::MAX_WIDTH - 1);
      end else begin
         col_last = sconv_pkg::COL_BITS'(width_ff - 1'b1);
      end
      if (height_ff == '0) begin
         row_last = '0;
      end else if (int'(height_ff) > sconv_pkg::MAX_HEIGHT) begin
         row_last = sconv_pkg::ROW_BITS'(sconv_pkg::MAX_HEIGHT - 1);
      end else begin
         row_last = sconv_pkg::ROW_BITS'(height_ff - 1'b1);
      end
      if (int'(half_ff) > sconv_pkg::MAX_HALF) begin
         half_eff = sconv_pkg::HALF_BITS'(sconv_pkg::MAX_HALF);
      end else begin
         half_eff = half_ff;
      end
      tap_last = {half_eff, 1'b0};
   end

   // Controller and address walk
   sconv_pkg::state_type state_ff, state_in;
   logic [sconv_pkg::TAP_BITS-1:0] tx_ff, tx_in;
   logic [sconv_pkg::TAP_BITS-1:0] ty_ff, ty_in;
   logic [sconv_pkg::COL_BITS-1:0] col_ff;
   logic [sconv_pkg::ROW_BITS-1:0] row_ff;

   logic req_fire;
   logic out_free;
   logic issue;
   logic mem_we;
   logic rsp_valid_ff, rsp_valid_in;
   sconv_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Pipeline registers
   logic                           s1_valid_ff;
   sconv_pkg::tap_tag_type         s1_tag_ff;
   logic [sconv_pkg::PIXEL_BITS-1:0] pix_ff;
   logic                           s2_valid_ff;
   sconv_pkg::tap_tag_type         s2_tag_ff;
   logic signed [sconv_pkg::PROD_BITS-1:0] prod_ff, prod_in;
   logic                           s3_valid_ff;
   sconv_pkg::tap_tag_type         s3_tag_ff;
   logic signed [sconv_pkg::ACC_BITS-1:0]  rsum_ff, rsum_in;
   logic                           s4_valid_ff;
   logic                           s4_last_ff;
   logic signed [sconv_pkg::ACC_BITS-1:0]  vprod_ff, vprod_in;
   logic signed [sconv_pkg::ACC_BITS-1:0]  total_ff, total_in;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == sconv_pkg::ST_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;
   assign mem_we    = req_fire && (req_data.op == sconv_pkg::OP_WRITE);

   always_comb begin
      state_in     = state_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      issue        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         sconv_pkg::ST_IDLE: begin
            tx_in = '0;
            ty_in = '0;
            if (req_fire) begin
               if (req_data.op == sconv_pkg::OP_READ) begin
                  state_in = sconv_pkg::ST_ISSUE;
               end else begin
                  rsp_valid_in         = 1'b1;
                  rsp_data_in.filtered = '0;
                  rsp_data_in.is_read  = 1'b0;
               end
            end
         end
         sconv_pkg::ST_ISSUE: begin
            issue = 1'b1;
            if (tx_ff == tap_last) begin
               tx_in = '0;
               ty_in = ty_ff + 1'b1;
               if (ty_ff == tap_last) begin
                  state_in = sconv_pkg::ST_DRAIN;
               end
            end else begin
               tx_in = tx_ff + 1'b1;
            end
         end
         sconv_pkg::ST_DRAIN: begin
            if (s4_valid_ff && s4_last_ff) begin
               state_in = sconv_pkg::ST_FINISH;
            end
         end
         sconv_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.filtered = total_ff;
               rsp_data_in.is_read  = 1'b1;
               state_in             = sconv_pkg::ST_IDLE;
            end
         end
         default: state_in = sconv_pkg::ST_IDLE;
      endcase
   end

   // Clamped tap position
   logic signed [sconv_pkg::COL_BITS+1:0] x_raw;
   logic signed [sconv_pkg::ROW_BITS+1:0] y_raw;
   logic [sconv_pkg::COL_BITS-1:0]        x_pos;
   logic [sconv_pkg::ROW_BITS-1:0]        y_pos;
   logic [sconv_pkg::ADDR_BITS-1:0]       rd_addr;
   sconv_pkg::tap_tag_type                issue_tag;

   always_comb begin
      x_raw = $signed({2'b00, col_ff}) + $signed((sconv_pkg::COL_BITS+2)'(tx_ff))
            - $signed((sconv_pkg::COL_BITS+2)'(half_eff));
      y_raw = $signed({2'b00, row_ff}) + $signed((sconv_pkg::ROW_BITS+2)'(ty_ff))
            - $signed((sconv_pkg::ROW_BITS+2)'(half_eff));
      if (x_raw < 0) begin
         x_pos = '0;
      end else if (x_raw > $signed({2'b00, col_last})) begin
         x_pos = col_last;
      end else begin
         x_pos = x_raw[sconv_pkg::COL_BITS-1:0];
      end
      if (y_raw < 0) begin
         y_pos = '0;
      end else if (y_raw > $signed({2'b00, row_last})) begin
         y_pos = row_last;
      end else begin
         y_pos = y_raw[sconv_pkg::ROW_BITS-1:0];
      end
      rd_addr              = {y_pos, x_pos};
      issue_tag.row_first  = (tx_ff == '0);
      issue_tag.row_last   = (tx_ff == tap_last);
      issue_tag.frame_last = (tx_ff == tap_last) && (ty_ff == tap_last);
      issue_tag.tap_x      = tx_ff;
      issue_tag.tap_y      = ty_ff;
   end

   // Frame store: one write port, one registered read port
   logic [sconv_pkg::PIXEL_BITS-1:0] pixel_mem [0:sconv_pkg::MEM_DEPTH-1];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pixel_mem[{req_data.row, req_data.column}] <= req_data.pixel_in;
      end
      pix_ff <= pixel_mem[rd_addr];
   end

   // Horizontal product, row accumulation, vertical product, frame accumulation
   always_comb begin
      prod_in = $signed(sconv_pkg::tap_coeff(kx_ff, s1_tag_ff.tap_x))
              * $signed({1'b0, pix_ff});
      if (s2_tag_ff.row_first) begin
         rsum_in = sconv_pkg::ACC_BITS'(prod_ff);
      end else begin
         rsum_in = rsum_ff + sconv_pkg::ACC_BITS'(prod_ff);
      end
      vprod_in = sconv_pkg::ACC_BITS'(sconv_pkg::tap_coeff(ky_ff, s3_tag_ff.tap_y)) * rsum_ff;
      if (req_fire) begin
         total_in = '0;
      end else if (s4_valid_ff) begin
         total_in = total_ff + vprod_ff;
      end else begin
         total_in = total_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sconv_pkg::ST_IDLE;
         tx_ff        <= '0;
         ty_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tx_ff        <= tx_in;
         ty_ff        <= ty_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_valid_ff  <= issue;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff && s2_tag_ff.row_last;
         s4_valid_ff  <= s3_valid_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         col_ff <= req_data.column;
         row_ff <= req_data.row;
      end
      s1_tag_ff   <= issue_tag;
      s2_tag_ff   <= s1_tag_ff;
      prod_ff     <= prod_in;
      if (s2_valid_ff) begin
         rsum_ff   <= rsum_in;
         s3_tag_ff <= s2_tag_ff;
      end
      vprod_ff    <= vprod_in;
      s4_last_ff  <= s3_tag_ff.frame_last;
      total_ff    <= total_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- design/sconv_checker.sv -----
// Port-level checker for the separable convolution block, bound to the top level.
module sconv_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input sconv_pkg::req_type                   req_data,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input sconv_pkg::rsp_type                   rsp_data,
   input logic                                 csr_we,
   input logic [sconv_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [sconv_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   // Reset empties the response register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A write response always carries zero
   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_read |-> rsp_data.filtered == '0)
      else $error("write response with nonzero value");

   // An accepted write is answered in the next cycle
   a_write_resp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.op == sconv_pkg::OP_WRITE
      |=> rsp_valid && !rsp_data.is_read)
      else $error("write beat not answered next cycle");

   // A read holds off new requests while the kernel is walked
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.op == sconv_pkg::OP_READ |=> !req_ready)
      else $error("request taken during a read");

   // A stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

endmodule

bind separable_convolution_clamp_top sconv_checker u_sconv_checker (.*);
